// ===== rtl/core/lpcd_pkg.sv =====
// Shared types and constants for the length-prefixed chunk deframer.
`timescale 1ns / 1ps

package lpcd_pkg;

  // Result kind codes
  localparam logic [2:0] KIND_HDR  = 3'd0;
  localparam logic [2:0] KIND_INT  = 3'd1;
  localparam logic [2:0] KIND_STR  = 3'd2;
  localparam logic [2:0] KIND_ESTR = 3'd3;
  localparam logic [2:0] KIND_EMSG = 3'd4;
  localparam logic [2:0] KIND_ERR  = 3'd5;

  // Parser phases, one-hot
  typedef enum logic [6:0] {
    PH_HLEN   = 7'b0000001,
    PH_HEADER = 7'b0000010,
    PH_COUNT  = 7'b0000100,
    PH_TYPE   = 7'b0001000,
    PH_FIELD  = 7'b0010000,
    PH_STRING = 7'b0100000,
    PH_HALT   = 7'b1000000
  } phase_t;

  // One result transaction
  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
    logic [30:0]        chunk_number;
    logic               chunk_end;
    logic               message_end;
  } result_t;

endpackage

// ===== rtl/core/lpcd_parser.sv =====
// Byte-at-a-time message parser: phase state, field assembly and counters.
`timescale 1ns / 1ps

module lpcd_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic [7:0]           byte_in,
  output logic                 res_valid,
  output lpcd_pkg::result_t    res
);

  lpcd_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [23:0] field_r, field_nxt;
  logic [30:0] bytes_left_r, bytes_left_nxt;
  logic [30:0] chunks_left_r, chunks_left_nxt;
  logic [30:0] chunk_cnt_r, chunk_cnt_nxt;
  logic        chunk_type_r, chunk_type_nxt;

  logic [31:0] field_full;
  logic        field_done;
  logic [30:0] bytes_dec;
  logic [30:0] chunks_dec;
  logic        last_chunk;

  assign field_full = {byte_in, field_r};
  assign field_done = (cnt_r == 2'd3);
  assign bytes_dec  = bytes_left_r - 31'd1;
  assign chunks_dec = chunks_left_r - 31'd1;
  assign last_chunk = (chunks_left_r == 31'd0);

  // Next-state and result logic for one byte
  always_comb begin
    phase_nxt       = phase_r;
    cnt_nxt         = cnt_r;
    field_nxt       = field_r;
    bytes_left_nxt  = bytes_left_r;
    chunks_left_nxt = chunks_left_r;
    chunk_cnt_nxt   = chunk_cnt_r;
    chunk_type_nxt  = chunk_type_r;
    res_valid       = 1'b0;
    res             = '0;

    // Little-endian field collection, shared by the header-length, count and chunk-field phases
    if (phase_r == lpcd_pkg::PH_HLEN || phase_r == lpcd_pkg::PH_COUNT ||
        phase_r == lpcd_pkg::PH_FIELD) begin
      if (field_done) begin
        cnt_nxt   = 2'd0;
        field_nxt = '0;
      end else begin
        cnt_nxt = cnt_r + 2'd1;
        case (cnt_r)
          2'd0:    field_nxt = {field_r[23:8], byte_in};
          2'd1:    field_nxt = {field_r[23:16], byte_in, field_r[7:0]};
          default: field_nxt = {byte_in, field_r[15:0]};
        endcase
      end
    end

    case (phase_r)
      lpcd_pkg::PH_HLEN: begin
        if (field_done) begin
          if (field_full[31]) begin
            res_valid = 1'b1;
            res.kind  = lpcd_pkg::KIND_ERR;
            res.chunk_number = chunk_cnt_r;
            phase_nxt = lpcd_pkg::PH_HALT;
          end else if (field_full == 32'd0) begin
            phase_nxt = lpcd_pkg::PH_COUNT;
          end else begin
            bytes_left_nxt = field_full[30:0];
            phase_nxt      = lpcd_pkg::PH_HEADER;
          end
        end
      end
      lpcd_pkg::PH_HEADER: begin
        res_valid      = 1'b1;
        res.kind       = lpcd_pkg::KIND_HDR;
        res.value      = {24'd0, byte_in};
        bytes_left_nxt = bytes_dec;
        if (bytes_dec == 31'd0) phase_nxt = lpcd_pkg::PH_COUNT;
      end
      lpcd_pkg::PH_COUNT: begin
        if (field_done) begin
          if (field_full[31]) begin
            res_valid = 1'b1;
            res.kind  = lpcd_pkg::KIND_ERR;
            res.chunk_number = chunk_cnt_r;
            phase_nxt = lpcd_pkg::PH_HALT;
          end else begin
            chunk_cnt_nxt = '0;
            if (field_full == 32'd0) begin
              res_valid       = 1'b1;
              res.kind        = lpcd_pkg::KIND_EMSG;
              res.message_end = 1'b1;
              phase_nxt       = lpcd_pkg::PH_HLEN;
            end else begin
              chunks_left_nxt = field_full[30:0];
              phase_nxt       = lpcd_pkg::PH_TYPE;
            end
          end
        end
      end
      lpcd_pkg::PH_TYPE: begin
        chunks_left_nxt = chunks_dec;
        if (byte_in > 8'd1) begin
          res_valid = 1'b1;
          res.kind  = lpcd_pkg::KIND_ERR;
          res.chunk_number = chunk_cnt_r;
          phase_nxt = lpcd_pkg::PH_HALT;
        end else begin
          chunk_type_nxt = byte_in[0];
          phase_nxt      = lpcd_pkg::PH_FIELD;
        end
      end
      lpcd_pkg::PH_FIELD: begin
        if (field_done) begin
          if (!chunk_type_r || (!field_full[31] && field_full == 32'd0)) begin
            // Integer chunk or empty string: chunk ends here
            res_valid        = 1'b1;
            res.kind         = chunk_type_r ? lpcd_pkg::KIND_ESTR : lpcd_pkg::KIND_INT;
            res.value        = chunk_type_r ? 32'sd0 : field_full;
            res.chunk_number = chunk_cnt_r;
            res.chunk_end    = 1'b1;
            res.message_end  = last_chunk;
            if (last_chunk) begin
              phase_nxt     = lpcd_pkg::PH_HLEN;
              chunk_cnt_nxt = '0;
            end else begin
              phase_nxt     = lpcd_pkg::PH_TYPE;
              chunk_cnt_nxt = chunk_cnt_r + 31'd1;
            end
          end else if (field_full[31]) begin
            res_valid = 1'b1;
            res.kind  = lpcd_pkg::KIND_ERR;
            res.chunk_number = chunk_cnt_r;
            phase_nxt = lpcd_pkg::PH_HALT;
          end else begin
            bytes_left_nxt = field_full[30:0];
            phase_nxt      = lpcd_pkg::PH_STRING;
          end
        end
      end
      lpcd_pkg::PH_STRING: begin
        res_valid        = 1'b1;
        res.kind         = lpcd_pkg::KIND_STR;
        res.value        = {24'd0, byte_in};
        res.chunk_number = chunk_cnt_r;
        bytes_left_nxt   = bytes_dec;
        if (bytes_dec == 31'd0) begin
          res.chunk_end   = 1'b1;
          res.message_end = last_chunk;
          if (last_chunk) begin
            phase_nxt     = lpcd_pkg::PH_HLEN;
            chunk_cnt_nxt = '0;
          end else begin
            phase_nxt     = lpcd_pkg::PH_TYPE;
            chunk_cnt_nxt = chunk_cnt_r + 31'd1;
          end
        end
      end
      default: begin
        // Halted: bytes are dropped until reset
        phase_nxt = lpcd_pkg::PH_HALT;
      end
    endcase
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= lpcd_pkg::PH_HLEN;
      cnt_r         <= '0;
      field_r       <= '0;
      bytes_left_r  <= '0;
      chunks_left_r <= '0;
      chunk_cnt_r   <= '0;
      chunk_type_r  <= 1'b0;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      cnt_r         <= cnt_nxt;
      field_r       <= field_nxt;
      bytes_left_r  <= bytes_left_nxt;
      chunks_left_r <= chunks_left_nxt;
      chunk_cnt_r   <= chunk_cnt_nxt;
      chunk_type_r  <= chunk_type_nxt;
    end
  end

endmodule

// ===== rtl/core/length_prefixed_chunk_deframer_top.sv =====
// Top level of the length-prefixed chunk deframer: input and result registers.
`timescale 1ns / 1ps

// Takes one stream byte per cycle unless stalled; at most one result per byte.
// A byte passes through an input register, the parser updates its state from
// it, and any result lands in an output register, which drives out_valid.
// Throughput is one byte per cycle while out_ready stays high; the parser
// steps only when the output register is free or being drained. After an
// error result every further byte is accepted and dropped until reset.
module length_prefixed_chunk_deframer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_kind,
  output logic signed [31:0] out_value,
  output logic [30:0]        out_chunk_number,
  output logic               out_chunk_end,
  output logic               out_message_end
);

  logic              in_valid_r;
  logic [7:0]        in_byte_r;
  logic              out_valid_r;
  lpcd_pkg::result_t out_res_r;
  logic              step;
  logic              res_valid;
  lpcd_pkg::result_t res;

  // Parser consumes the held byte when the result slot can take its output
  assign step     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
    end
  end

  lpcd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step),
    .byte_in   (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_res_r.kind;
  assign out_value        = out_res_r.value;
  assign out_chunk_number = out_res_r.chunk_number;
  assign out_chunk_end    = out_res_r.chunk_end;
  assign out_message_end  = out_res_r.message_end;

endmodule

// ===== tb/tb_length_prefixed_chunk_deframer_top.sv =====
// Self-checking testbench for the length-prefixed chunk deframer top level.
`timescale 1ns / 1ps

module tb_length_prefixed_chunk_deframer_top;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 8;

  // DUT connections
  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [7:0]         in_byte   = 8'd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_kind;
  logic signed [31:0] out_value;
  logic [30:0]        out_chunk_number;
  logic               out_chunk_end;
  logic               out_message_end;

  length_prefixed_chunk_deframer_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_value        (out_value),
    .out_chunk_number (out_chunk_number),
    .out_chunk_end    (out_chunk_end),
    .out_message_end  (out_message_end)
  );

  // Test control
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_req       = 0;
  int hold_left      = 0;
  int bytes_sent     = 0;
  int mismatch_count = 0;

  // Results predicted from accepted bytes, oldest first
  lpcd_pkg::result_t expected_results[$];

  // Parser state mirrored by the predictor
  lpcd_pkg::phase_t prd_phase     = lpcd_pkg::PH_HLEN;
  logic [1:0]       prd_field_cnt = 2'd0;
  logic [31:0]      prd_field     = 32'd0;
  logic [30:0]      prd_bytes     = 31'd0;
  logic [30:0]      prd_chunks    = 31'd0;
  logic [30:0]      prd_chunk_idx = 31'd0;
  logic             prd_is_string = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void push_result(input logic [2:0] kind, input logic [31:0] value,
                                      input logic [30:0] num, input logic cend,
                                      input logic mend);
    lpcd_pkg::result_t r;
    r.kind         = kind;
    r.value        = value;
    r.chunk_number = num;
    r.chunk_end    = cend;
    r.message_end  = mend;
    expected_results.push_back(r);
  endfunction

  // Little-endian field assembly; returns 1 on the fourth byte
  function automatic logic collect_field(input logic [7:0] b);
    prd_field = prd_field | ({24'd0, b} << (8 * prd_field_cnt));
    if (prd_field_cnt == 2'd3) begin
      prd_field_cnt = 2'd0;
      return 1'b1;
    end
    prd_field_cnt = prd_field_cnt + 2'd1;
    return 1'b0;
  endfunction

  function automatic void raise_error();
    push_result(lpcd_pkg::KIND_ERR, 32'd0, prd_chunk_idx, 1'b0, 1'b0);
    prd_phase = lpcd_pkg::PH_HALT;
  endfunction

  function automatic void advance_chunk();
    if (prd_chunks == 31'd0) begin
      prd_phase     = lpcd_pkg::PH_HLEN;
      prd_chunk_idx = 31'd0;
    end else begin
      prd_chunk_idx = prd_chunk_idx + 31'd1;
      prd_phase     = lpcd_pkg::PH_TYPE;
    end
  endfunction

  function automatic void predict_byte(input logic [7:0] b);
    logic [31:0] f;
    logic        last;
    case (prd_phase)
      lpcd_pkg::PH_HLEN: begin
        if (collect_field(b)) begin
          f = prd_field;
          prd_field = 32'd0;
          if (f[31]) raise_error();
          else if (f == 32'd0) prd_phase = lpcd_pkg::PH_COUNT;
          else begin
            prd_bytes = f[30:0];
            prd_phase = lpcd_pkg::PH_HEADER;
          end
        end
      end
      lpcd_pkg::PH_HEADER: begin
        push_result(lpcd_pkg::KIND_HDR, {24'd0, b}, 31'd0, 1'b0, 1'b0);
        prd_bytes = prd_bytes - 31'd1;
        if (prd_bytes == 31'd0) prd_phase = lpcd_pkg::PH_COUNT;
      end
      lpcd_pkg::PH_COUNT: begin
        if (collect_field(b)) begin
          f = prd_field;
          prd_field = 32'd0;
          if (f[31]) raise_error();
          else begin
            prd_chunk_idx = 31'd0;
            if (f == 32'd0) begin
              push_result(lpcd_pkg::KIND_EMSG, 32'd0, 31'd0, 1'b0, 1'b1);
              prd_phase = lpcd_pkg::PH_HLEN;
            end else begin
              prd_chunks = f[30:0];
              prd_phase  = lpcd_pkg::PH_TYPE;
            end
          end
        end
      end
      lpcd_pkg::PH_TYPE: begin
        prd_chunks = prd_chunks - 31'd1;
        if (b > 8'd1) raise_error();
        else begin
          prd_is_string = b[0];
          prd_phase     = lpcd_pkg::PH_FIELD;
        end
      end
      lpcd_pkg::PH_FIELD: begin
        if (collect_field(b)) begin
          f = prd_field;
          prd_field = 32'd0;
          last = (prd_chunks == 31'd0);
          if (!prd_is_string) begin
            push_result(lpcd_pkg::KIND_INT, f, prd_chunk_idx, 1'b1, last);
            advance_chunk();
          end else if (f[31]) begin
            raise_error();
          end else if (f == 32'd0) begin
            push_result(lpcd_pkg::KIND_ESTR, 32'd0, prd_chunk_idx, 1'b1, last);
            advance_chunk();
          end else begin
            prd_bytes = f[30:0];
            prd_phase = lpcd_pkg::PH_STRING;
          end
        end
      end
      lpcd_pkg::PH_STRING: begin
        prd_bytes = prd_bytes - 31'd1;
        if (prd_bytes == 31'd0) begin
          last = (prd_chunks == 31'd0);
          push_result(lpcd_pkg::KIND_STR, {24'd0, b}, prd_chunk_idx, 1'b1, last);
          advance_chunk();
        end else begin
          push_result(lpcd_pkg::KIND_STR, {24'd0, b}, prd_chunk_idx, 1'b0, 1'b0);
        end
      end
      default: ;  // halted: byte dropped
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and receiver
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t MISMATCH %s: got 0x%08h expected 0x%08h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_result();
    lpcd_pkg::result_t e;
    if (expected_results.size() == 0) begin
      report_mismatch("result with no transaction pending", {29'd0, out_kind}, 32'd0);
    end else begin
      e = expected_results.pop_front();
      if (out_kind !== e.kind)
        report_mismatch("kind", {29'd0, out_kind}, {29'd0, e.kind});
      if (out_value !== e.value)
        report_mismatch("value", out_value, e.value);
      if (out_chunk_number !== e.chunk_number)
        report_mismatch("chunk_number", {1'b0, out_chunk_number}, {1'b0, e.chunk_number});
      if (out_chunk_end !== e.chunk_end)
        report_mismatch("chunk_end", {31'd0, out_chunk_end}, {31'd0, e.chunk_end});
      if (out_message_end !== e.message_end)
        report_mismatch("message_end", {31'd0, out_message_end}, {31'd0, e.message_end});
    end
  endtask

  // Check each result transaction, then pick the next cycle's ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result();
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Ends the run when no transaction moves for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  task automatic send_byte(input logic [7:0] b);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b);
    bytes_sent++;
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) send_byte(w[8*i +: 8]);
  endtask

  task automatic send_string_chunk(input int len);
    send_byte(8'd1);
    send_word(len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)));
  endtask

  // Stop offering bytes until every predicted result has come out
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly short lengths, sometimes a longer one
  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 0;
    if (r < 90) return $urandom_range(1, 6);
    return $urandom_range(7, 40);
  endfunction

  function automatic logic [31:0] pick_int();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 32'h8000_0000;
    if (r < 20) return 32'h7FFF_FFFF;
    if (r < 25) return 32'h0000_0000;
    if (r < 30) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic send_header(input int hlen);
    send_word(hlen);
    for (int i = 0; i < hlen; i++) send_byte(8'($urandom_range(255)));
  endtask

  task automatic send_random_chunk();
    if ($urandom_range(1)) begin
      send_string_chunk(pick_len());
    end else begin
      send_byte(8'd0);
      send_word(pick_int());
    end
  endtask

  task automatic send_random_message();
    int nchunks;
    int r;
    r = $urandom_range(99);
    if (r < 10) nchunks = 0;
    else if (r < 90) nchunks = $urandom_range(1, 5);
    else nchunks = $urandom_range(6, 12);
    send_header(pick_len());
    send_word(nchunks);
    for (int i = 0; i < nchunks; i++) send_random_chunk();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty header and zero chunk count
  task automatic test_empty_message();
    send_word(32'd0);
    send_word(32'd0);
  endtask

  // One header byte, a most-negative integer, then an empty string as last chunk
  task automatic test_mixed_message();
    send_word(32'd1);
    send_byte(8'hFF);
    send_word(32'd2);
    send_byte(8'd0);
    send_word(32'h8000_0000);
    send_string_chunk(0);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int nbytes);
    int start;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = bytes_sent;
    while (bytes_sent - start < nbytes) send_random_message();
    pause_until_drained();
  endtask

  // Receiver holds off while a long header keeps the sender busy
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 300;
    send_header(60);
    send_word(32'd2);
    send_string_chunk(12);
    send_byte(8'd0);
    send_word($urandom);
    pause_until_drained();
  endtask

  // One malformed message ends the stream; later bytes must be dropped
  task automatic test_error_halt();
    int sel;
    int nvalid;
    sel    = $urandom_range(3);
    nvalid = $urandom_range(0, 3);
    send_idle_pct = 20;
    recv_idle_pct = 20;
    if (sel == 0) begin
      send_word($urandom | 32'h8000_0000);
    end else begin
      send_header(pick_len());
      if (sel == 1) begin
        send_word($urandom | 32'h8000_0000);
      end else begin
        send_word(nvalid + 2);
        for (int i = 0; i < nvalid; i++) send_random_chunk();
        if (sel == 2) begin
          send_byte(8'($urandom_range(2, 255)));
        end else begin
          send_byte(8'd1);
          send_word($urandom | 32'h8000_0000);
        end
      end
    end
    for (int i = 0; i < 24; i++) send_byte(8'($urandom_range(255)));
    pause_until_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_message();
    test_mixed_message();
    pause_until_drained();

    test_random_traffic(20, 64, 480);
    test_random_traffic(64, 20, 480);
    test_random_traffic(0, 0, 480);
    test_backpressure();
    test_error_halt();

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lpcd_pkg.sv
rtl/core/lpcd_parser.sv
rtl/core/length_prefixed_chunk_deframer_top.sv
tb/tb_length_prefixed_chunk_deframer_top.sv
